// File: rtl/ios_pkg.sv
`default_nettype none
package ios_pkg;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Membership is an epoch tag per value; tag zero never matches a live epoch.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam int TDATA_W = 16;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [EPOCH_W-1:0]  epoch_t;

endpackage
`default_nettype wire

// File: rtl/ios_ram.sv
`default_nettype none
module ios_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/insertion_ordered_set.sv
// Add, delete and pop: after accept the request passes through S_EVAL, S_W2 and S_RESP before
// the next is taken (read both link memories, write own entry and a neighbor link, write the rest, respond).
// Add of a member or delete of a non-member: S_EVAL goes straight to S_RESP.
// Out-of-range value, pop on empty set and clear (unless it sweeps): the request goes straight to S_RESP;
// a result held by out_tready low holds the next request. Reset and every 255th clear run
// a membership sweep over every value with in_tready low; rst_n low (sync) empties the set.
`default_nettype none
module insertion_ordered_set #(
  parameter int VALUE_COUNT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [ios_pkg::TDATA_W-1:0]  in_tdata,   // cmd[1:0], value[11:2], zero
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [ios_pkg::TDATA_W-1:0]  out_tdata   // status[1:0], popped_value[11:2], zero
);

  localparam int IDX_W  = $clog2(VALUE_COUNT);
  localparam int LINK_W = IDX_W + 1;
  localparam int LW     = ios_pkg::EPOCH_W + LINK_W;
  localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(VALUE_COUNT);
  localparam logic [IDX_W-1:0]  SWEEP_LAST = IDX_W'(VALUE_COUNT - 1);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_W2    = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  ios_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]       val_r, val_nxt;
  logic [LINK_W-1:0]      p_r, p_nxt;
  logic [LINK_W-1:0]      nx_r, nx_nxt;
  ios_pkg::status_t       status_r, status_nxt;
  ios_pkg::value_t        popped_r, popped_nxt;
  logic [IDX_W-1:0]       tail_r, tail_nxt;
  logic                   empty_r, empty_nxt;
  ios_pkg::epoch_t        epoch_r, epoch_nxt;
  logic [IDX_W-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic                   sweep_resp_r, sweep_resp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ios_pkg::TDATA_W-1:0] out_data_r, out_data_nxt;

  // prev/tag memory: {epoch tag, prev link}; next memory: next link
  logic              l_we, n_we;
  logic [IDX_W-1:0]  l_waddr, n_waddr, rd_addr;
  logic [LW-1:0]     l_wdata, l_rdata;
  logic [LINK_W-1:0] n_wdata, n_rdata;

  ios_pkg::cmd_t     in_cmd;
  ios_pkg::value_t   in_value;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range_bad;
  logic              in_fire;
  ios_pkg::epoch_t   rd_epoch;
  logic [LINK_W-1:0] rd_prev;
  logic              rd_member;

  assign in_cmd       = in_tdata[1:0];
  assign in_value     = in_tdata[11:2];
  assign in_idx       = IDX_W'(32'(in_value));
  assign in_range_bad = 32'(in_value) >= 32'(VALUE_COUNT);
  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign rd_addr      = (in_cmd == ios_pkg::CMD_POP) ? tail_r : in_idx;
  assign rd_epoch     = l_rdata[LW-1:LINK_W];
  assign rd_prev      = l_rdata[LINK_W-1:0];
  assign rd_member    = (rd_epoch == epoch_r);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  ios_ram #(.WIDTH(LW), .DEPTH(VALUE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (l_rdata)
  );

  ios_ram #(.WIDTH(LINK_W), .DEPTH(VALUE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (n_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    p_nxt          = p_r;
    nx_nxt         = nx_r;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    epoch_nxt      = epoch_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    sweep_resp_nxt = sweep_resp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    l_we    = 1'b0;
    l_waddr = val_r;
    l_wdata = {epoch_r, p_r};
    n_we    = 1'b0;
    n_waddr = val_r;
    n_wdata = LINK_NONE;

    unique case (state_r)
      S_SWEEP: begin
        l_we          = 1'b1;
        l_waddr       = sweep_cnt_r;
        l_wdata       = {ios_pkg::EPOCH_NONE, LINK_NONE};
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == SWEEP_LAST) begin
          sweep_cnt_nxt = '0;
          state_nxt     = sweep_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_cmd;
          val_nxt    = in_idx;
          popped_nxt = '0;
          status_nxt = ios_pkg::STATUS_OK;
          state_nxt  = S_EVAL;
          case (in_cmd) inside
            ios_pkg::CMD_ADD, ios_pkg::CMD_DELETE: begin
              if (in_range_bad) begin
                status_nxt = ios_pkg::STATUS_BAD;
                state_nxt  = S_RESP;
              end
            end
            ios_pkg::CMD_POP: begin
              val_nxt = tail_r;
              if (empty_r) begin
                status_nxt = ios_pkg::STATUS_EMPTY;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              // clear: move to a new epoch, sweep only when the tags wrap
              tail_nxt  = '0;
              empty_nxt = 1'b1;
              state_nxt = S_RESP;
              if (epoch_r == ios_pkg::EPOCH_LAST) begin
                epoch_nxt      = ios_pkg::EPOCH_FIRST;
                sweep_resp_nxt = 1'b1;
                sweep_cnt_nxt  = '0;
                state_nxt      = S_SWEEP;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
            end
          endcase
        end
      end
      S_EVAL: begin
        state_nxt = S_W2;
        if (cmd_r == ios_pkg::CMD_ADD) begin
          if (rd_member) begin
            status_nxt = ios_pkg::STATUS_BAD;
            state_nxt  = S_RESP;
          end else begin
            l_we    = 1'b1;
            l_wdata = {epoch_r, empty_r ? LINK_NONE : {1'b0, tail_r}};
            // link old tail forward to the new value
            n_we      = !empty_r;
            n_waddr   = tail_r;
            n_wdata   = {1'b0, val_r};
            tail_nxt  = val_r;
            empty_nxt = 1'b0;
          end
        end else if (cmd_r == ios_pkg::CMD_DELETE && !rd_member) begin
          status_nxt = ios_pkg::STATUS_BAD;
          state_nxt  = S_RESP;
        end else begin
          // unlink: drop membership, point prev forward past this value
          l_we    = 1'b1;
          l_wdata = {ios_pkg::EPOCH_NONE, rd_prev};
          n_we    = (rd_prev != LINK_NONE);
          n_waddr = rd_prev[IDX_W-1:0];
          n_wdata = n_rdata;
          p_nxt   = rd_prev;
          nx_nxt  = n_rdata;
          if (cmd_r == ios_pkg::CMD_POP) begin
            popped_nxt = ios_pkg::VALUE_W'(32'(val_r));
          end
          if (tail_r == val_r) begin
            if (rd_prev != LINK_NONE) begin
              tail_nxt = rd_prev[IDX_W-1:0];
            end else begin
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end
          end
        end
      end
      S_W2: begin
        state_nxt = S_RESP;
        if (cmd_r == ios_pkg::CMD_ADD) begin
          n_we    = 1'b1;
          n_waddr = val_r;
          n_wdata = LINK_NONE;
        end else begin
          l_we    = (nx_r != LINK_NONE);
          l_waddr = nx_r[IDX_W-1:0];
          l_wdata = {epoch_r, p_r};
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(ios_pkg::TDATA_W - ios_pkg::VALUE_W - ios_pkg::STATUS_W){1'b0}},
                           popped_r, status_r};
          sweep_resp_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      tail_r       <= '0;
      empty_r      <= 1'b1;
      epoch_r      <= ios_pkg::EPOCH_FIRST;
      sweep_cnt_r  <= '0;
      sweep_resp_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tail_r       <= tail_nxt;
      empty_r      <= empty_nxt;
      epoch_r      <= epoch_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      sweep_resp_r <= sweep_resp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    p_r        <= p_nxt;
    nx_r       <= nx_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    out_data_r <= out_data_nxt;
  end

  a_empty_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> tail_r == '0)
    else $error("empty set with nonzero tail");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != ios_pkg::EPOCH_NONE)
    else $error("live epoch equals the free tag");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request taken while another is in flight");

  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1:0] == ios_pkg::STATUS_EMPTY |-> out_data_r[11:2] == '0)
    else $error("pop on empty set returned a value");

  a_sweep_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> !in_tready && l_we)
    else $error("sweep not writing or accepting requests");

endmodule
`default_nettype wire
